### rtl/tlin_pkg.sv
// Shared constants and codes for the thermistor/humidity linearizer.
`timescale 1ns / 1ps
package tlin_pkg;

	// default table geometry
	localparam int TEMP_ENTRIES_DEF = 154;
	localparam int HUM_ROWS_DEF     = 41;
	localparam int HUM_COLS_DEF     = 71;
	localparam int SAMPLE_BITS_DEF  = 10;

	// field widths
	localparam int ADDR_W  = 12;
	localparam int WORD_W  = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	// input modes
	localparam logic [1:0] MODE_TEMP_LOAD = 2'd0;
	localparam logic [1:0] MODE_HUM_LOAD  = 2'd1;
	localparam logic [1:0] MODE_ROOM      = 2'd2;
	localparam logic [1:0] MODE_HUM       = 2'd3;

	// status codes
	localparam logic [1:0] ST_NORMAL = 2'd0;
	localparam logic [1:0] ST_OPEN   = 2'd1;
	localparam logic [1:0] ST_SHORT  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROOM_OPEN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROOM_SHORT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HUM_SHORT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HUM_OPEN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM    = 3'd4;

	// register reset values
	localparam logic [8:0] ROOM_OPEN_RST  = 9'd30;
	localparam logic [8:0] ROOM_SHORT_RST = 9'd500;
	localparam logic [9:0] HUM_SHORT_RST  = 10'd1006;
	localparam logic [9:0] HUM_OPEN_RST   = 10'd8;
	localparam logic [2:0] CONFIRM_RST    = 3'd3;

	// conversion constants
	localparam int F_BASE           = 5;
	localparam int C_OFFSET         = 15;
	localparam int HUM_BASE         = 20;
	localparam int HUM_SHORT_VALUE  = 99;
	localparam int OPEN_MIN_CELSIUS = 30;

endpackage

### rtl/tlin_if.sv
// Input and output channel interfaces of the linearizer.
`timescale 1ns / 1ps
interface tlin_in_if #(parameter int SAMPLE_BITS = 10);
	logic                   valid;
	logic                   ready;
	logic [1:0]             mode;
	logic [11:0]            table_addr;
	logic [15:0]            table_word;
	logic [SAMPLE_BITS-1:0] sample;
	modport source (output valid, mode, table_addr, table_word, sample, input ready);
	modport sink   (input valid, mode, table_addr, table_word, sample, output ready);
endinterface

interface tlin_out_if;
	logic        valid;
	logic        ready;
	logic        sensor_kind;
	logic [1:0]  status;
	logic [7:0]  temp_fahrenheit;
	logic [6:0]  temp_celsius_offset;
	logic [15:0] temp_scaled;
	logic [6:0]  humidity;
	modport source (output valid, sensor_kind, status, temp_fahrenheit,
		temp_celsius_offset, temp_scaled, humidity, input ready);
	modport sink   (input valid, sensor_kind, status, temp_fahrenheit,
		temp_celsius_offset, temp_scaled, humidity, output ready);
endinterface

### rtl/tlin_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module tlin_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 154,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### rtl/tlin_search.sv
// Nearest-entry binary search over a table held in a registered-read RAM.
`timescale 1ns / 1ps
module tlin_search #(
	parameter int IDX_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [IDX_W-1:0]  last,
	input  logic [15:0]       value,
	input  logic [15:0]       rd_data,
	output logic [IDX_W-1:0]  rd_addr,
	output logic              done,
	output logic [IDX_W-1:0]  idx
);
	localparam int SW = IDX_W + 2;
	localparam logic [2:0] S_IDLE = 3'd0, S_FIRST = 3'd1, S_LAST = 3'd2,
		S_PROBE = 3'd3, S_FIN_LO = 3'd4, S_FIN_HI = 3'd5;

	logic [2:0]        state_q, state_d;
	logic signed [SW-1:0] lo_q, lo_d, hi_q, hi_d;
	logic [IDX_W-1:0]  mid_q, mid_d, addr_d, idx_d;
	logic [15:0]       dm_q, dm_d;
	logic              fin;
	logic signed [SW-1:0] mid_s, nlo, nhi, sum;
	logic [15:0]       a, b;

	assign rd_addr = addr_d;

	// one probe per cycle: the address of the next probe goes to the RAM now
	always_comb begin
		state_d = state_q;
		lo_d    = lo_q;
		hi_d    = hi_q;
		mid_d   = mid_q;
		dm_d    = dm_q;
		addr_d  = mid_q;
		fin     = 1'b0;
		idx_d   = idx;
		mid_s   = SW'(mid_q);
		nlo     = lo_q;
		nhi     = hi_q;
		sum     = '0;
		a       = '0;
		b       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					addr_d  = '0;
					state_d = S_FIRST;
				end
			end
			S_FIRST: begin
				if (value <= rd_data) begin
					fin   = 1'b1;
					idx_d = '0;
				end else begin
					addr_d  = last;
					state_d = S_LAST;
				end
			end
			S_LAST: begin
				if (value >= rd_data) begin
					fin   = 1'b1;
					idx_d = last;
				end else begin
					lo_d    = '0;
					hi_d    = SW'(last);
					mid_d   = last >> 1;
					addr_d  = last >> 1;
					state_d = S_PROBE;
				end
			end
			S_PROBE: begin
				if (rd_data == value) begin
					fin   = 1'b1;
					idx_d = mid_q;
				end else begin
					if (rd_data > value) begin
						nhi = mid_s - SW'(1);
					end else begin
						nlo = mid_s + SW'(1);
					end
					sum = nlo + nhi;
					if (nlo <= nhi) begin
						lo_d   = nlo;
						hi_d   = nhi;
						mid_d  = IDX_W'(sum >>> 1);
						addr_d = IDX_W'(sum >>> 1);
					end else if (value < rd_data) begin
						// settled above the value: weigh against the entry below
						if (mid_q == '0) begin
							fin   = 1'b1;
							idx_d = '0;
						end else begin
							dm_d    = rd_data;
							addr_d  = mid_q - IDX_W'(1);
							state_d = S_FIN_LO;
						end
					end else begin
						// settled below the value: weigh against the entry above
						if (mid_q >= last) begin
							fin   = 1'b1;
							idx_d = last;
						end else begin
							dm_d    = rd_data;
							addr_d  = mid_q + IDX_W'(1);
							state_d = S_FIN_HI;
						end
					end
				end
			end
			S_FIN_LO: begin
				a     = dm_q - value;
				b     = value - rd_data;
				fin   = 1'b1;
				idx_d = (a <= b) ? mid_q : mid_q - IDX_W'(1);
			end
			S_FIN_HI: begin
				a     = rd_data - value;
				b     = value - dm_q;
				fin   = 1'b1;
				idx_d = (a <= b) ? mid_q + IDX_W'(1) : mid_q;
			end
			default: state_d = S_IDLE;
		endcase
		if (fin) begin
			state_d = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= fin;
		end
	end

	always_ff @(posedge clk) begin
		lo_q  <= lo_d;
		hi_q  <= hi_d;
		mid_q <= mid_d;
		dm_q  <= dm_d;
		idx   <= idx_d;
	end
endmodule

### rtl/thermistor_humidity_linearizer_unit.sv
// Top level of the thermistor/humidity linearizer.
`timescale 1ns / 1ps
// Table loads (temperature and humidity words) give no result and leave the
// unit idle. A room or humidity sample is accepted only when the unit is idle.
// Lookups go through the shared binary-search unit, which issues one RAM probe
// per cycle: it reads the first and last entries, then bisects the table, and
// may read one neighbouring entry to pick the nearest. An in-range room sample
// then runs the conversion states T_CONV1 to T_CONV3. An out-of-range room
// sample, or a humidity sample handled by the fault counter, skips the lookup.
// A finished result sits in the output register until taken; a new item may be
// accepted meanwhile, but its result waits until that register is free. Table
// entries never written must not be read.
module thermistor_humidity_linearizer_unit
	import tlin_pkg::*;
#(
	parameter int TEMP_ENTRIES = TEMP_ENTRIES_DEF,
	parameter int HUM_ROWS     = HUM_ROWS_DEF,
	parameter int HUM_COLS     = HUM_COLS_DEF,
	parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	tlin_in_if.sink               in_ch,
	tlin_out_if.source            out_ch
);
	localparam int HUM_DEPTH = HUM_ROWS * HUM_COLS;
	localparam int TA_W  = $clog2(TEMP_ENTRIES);
	localparam int HA_W  = (HUM_DEPTH > 1) ? $clog2(HUM_DEPTH) : 1;
	localparam int MAXN  = (TEMP_ENTRIES > HUM_COLS) ? TEMP_ENTRIES : HUM_COLS;
	localparam int IDX_W = $clog2(MAXN);
	localparam int RW    = (HUM_ROWS > 1) ? $clog2(HUM_ROWS) : 1;

	localparam logic [3:0] T_IDLE = 4'd0, T_EVAL = 4'd1, T_GO = 4'd2, T_WAIT = 4'd3,
		T_CONV1 = 4'd4, T_CONV2 = 4'd5, T_CONV3 = 4'd6, T_OUT = 4'd7;

	// configuration registers
	logic [8:0] room_open_q, room_short_q;
	logic [9:0] hum_short_q, hum_open_q;
	logic [2:0] confirm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_open_q  <= ROOM_OPEN_RST;
			room_short_q <= ROOM_SHORT_RST;
			hum_short_q  <= HUM_SHORT_RST;
			hum_open_q   <= HUM_OPEN_RST;
			confirm_q    <= CONFIRM_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROOM_OPEN:  room_open_q  <= cfg_data[8:0];
				CFG_ROOM_SHORT: room_short_q <= cfg_data[8:0];
				CFG_HUM_SHORT:  hum_short_q  <= cfg_data;
				CFG_HUM_OPEN:   hum_open_q   <= cfg_data;
				CFG_CONFIRM:    confirm_q    <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	logic [3:0] state_q;
	logic       in_xfer;
	assign in_ch.ready = (state_q == T_IDLE);
	assign in_xfer = in_ch.valid && in_ch.ready;

	// table RAMs, written straight from load transfers
	logic             t_we, h_we;
	logic [15:0]      t_rd, h_rd, s_rd;
	logic [IDX_W-1:0] s_addr, s_idx;
	logic             s_done, s_start;
	logic [HA_W-1:0]  base_q;
	logic [1:0]       mode_q;
	logic [SAMPLE_BITS-1:0] smp_q;

	assign t_we = in_xfer && (in_ch.mode == MODE_TEMP_LOAD)
		&& (32'(in_ch.table_addr) < TEMP_ENTRIES);
	assign h_we = in_xfer && (in_ch.mode == MODE_HUM_LOAD)
		&& (32'(in_ch.table_addr) < HUM_DEPTH);

	tlin_ram #(.WIDTH(WORD_W), .DEPTH(TEMP_ENTRIES)) u_temp_ram (
		.clk(clk), .we(t_we), .waddr(TA_W'(in_ch.table_addr)), .wdata(in_ch.table_word),
		.raddr(TA_W'(s_addr)), .rdata(t_rd)
	);

	tlin_ram #(.WIDTH(WORD_W), .DEPTH(HUM_DEPTH)) u_hum_ram (
		.clk(clk), .we(h_we), .waddr(HA_W'(in_ch.table_addr)), .wdata(in_ch.table_word),
		.raddr(base_q + HA_W'(s_addr)), .rdata(h_rd)
	);

	assign s_rd    = mode_q[0] ? h_rd : t_rd;
	assign s_start = (state_q == T_GO);

	tlin_search #(.IDX_W(IDX_W)) u_search (
		.clk(clk), .arst_n(arst_n), .start(s_start),
		.last(mode_q[0] ? IDX_W'(HUM_COLS - 1) : IDX_W'(TEMP_ENTRIES - 1)),
		.value(mode_q[0] ? 16'(smp_q) : 16'(smp_q >> 1)),
		.rd_data(s_rd), .rd_addr(s_addr), .done(s_done), .idx(s_idx)
	);

	// held state and staging
	logic [6:0]  rc_q, hv_q, c_q;
	logic [2:0]  fc_q;
	logic [1:0]  hs_q, rstat_q;
	logic [7:0]  f_q, d_q;
	logic        lt32_q;
	logic [6:0]  mag_q;
	logic [15:0] sc_q;
	logic        out_v_q;
	logic        out_load;

	// combinational helpers
	logic [15:0] ad_w, smp_w;
	logic        is_short, is_open;
	logic [3:0]  cnt;
	logic [6:0]  row7;
	logic [RW-1:0] row;
	logic [8:0]  f9;
	logic [7:0]  h8, cel8;
	logic [8:0]  x9;
	logic [23:0] magp;
	logic [21:0] divp;

	assign ad_w  = 16'(smp_q >> 1);
	assign smp_w = 16'(smp_q);
	assign is_short = smp_w > 16'(hum_short_q);
	assign is_open  = !is_short && (smp_w < 16'(hum_open_q))
		&& (rc_q >= 7'(OPEN_MIN_CELSIUS));
	assign cnt = 4'(fc_q) + 4'd1;
	assign row7 = (rc_q <= 7'(HUM_BASE)) ? 7'd0
		: ((rc_q - 7'(HUM_BASE) > 7'(HUM_ROWS - 1)) ? 7'(HUM_ROWS - 1) : rc_q - 7'(HUM_BASE));
	assign row  = RW'(row7);
	assign f9   = 9'(s_idx) + 9'(F_BASE);
	assign h8   = 8'(s_idx) + 8'(HUM_BASE);
	assign x9   = 9'(f_q) + 9'd49;
	// (d*10+9)/18 as a reciprocal multiply, exact over this range
	assign magp = (24'(d_q) * 24'd10 + 24'd9) * 24'd3641;
	// x/21 as a reciprocal multiply, exact for x below 400
	assign divp = 22'(x9) * 22'd3121;
	assign cel8 = lt32_q ? 8'(C_OFFSET) - 8'(mag_q) : 8'(mag_q) + 8'(C_OFFSET);

	// result moves into the output register when it is empty or being taken
	assign out_load = (state_q == T_OUT) && (!out_v_q || out_ch.ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			rc_q    <= '0;
			fc_q    <= '0;
			hs_q    <= ST_NORMAL;
			hv_q    <= '0;
		end else begin
			unique case (state_q)
				T_IDLE: begin
					if (in_xfer && (in_ch.mode == MODE_ROOM || in_ch.mode == MODE_HUM)) begin
						state_q <= T_EVAL;
					end
				end
				T_EVAL: begin
					if (mode_q == MODE_ROOM) begin
						if (ad_w < 16'(room_open_q) || ad_w > 16'(room_short_q)) begin
							rc_q    <= '0;
							state_q <= T_OUT;
						end else begin
							state_q <= T_GO;
						end
					end else if (is_short || is_open) begin
						// fault sample: count up toward confirmation
						if (cnt >= 4'(confirm_q)) begin
							fc_q <= confirm_q;
							hs_q <= is_short ? ST_SHORT : ST_OPEN;
							hv_q <= is_short ? 7'(HUM_SHORT_VALUE) : 7'd0;
						end else begin
							fc_q <= cnt[2:0];
						end
						state_q <= T_OUT;
					end else if (fc_q != 3'd0) begin
						fc_q    <= fc_q - 3'd1;
						state_q <= T_OUT;
					end else begin
						state_q <= T_GO;
					end
				end
				T_GO: state_q <= T_WAIT;
				T_WAIT: begin
					if (s_done) begin
						if (mode_q[0]) begin
							hs_q    <= ST_NORMAL;
							hv_q    <= (h8 > 8'd127) ? 7'd127 : h8[6:0];
							state_q <= T_OUT;
						end else begin
							state_q <= T_CONV1;
						end
					end
				end
				T_CONV1: state_q <= T_CONV2;
				T_CONV2: state_q <= T_CONV3;
				T_CONV3: begin
					rc_q    <= (cel8 > 8'd127) ? 7'd127 : cel8[6:0];
					state_q <= T_OUT;
				end
				T_OUT: begin
					if (out_load) begin
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	// output valid: set on load, cleared when the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mode_q <= in_ch.mode;
			smp_q  <= in_ch.sample;
		end
		if (state_q == T_EVAL) begin
			base_q <= HA_W'(row * HUM_COLS);
			f_q    <= '0;
			c_q    <= '0;
			sc_q   <= '0;
			if (ad_w < 16'(room_open_q)) begin
				rstat_q <= ST_OPEN;
			end else if (ad_w > 16'(room_short_q)) begin
				rstat_q <= ST_SHORT;
			end else begin
				rstat_q <= ST_NORMAL;
			end
		end
		if (state_q == T_WAIT && s_done) begin
			f_q <= (f9 > 9'd255) ? 8'd255 : f9[7:0];
		end
		if (state_q == T_CONV1) begin
			lt32_q <= f_q < 8'd32;
			d_q    <= (f_q > 8'd32) ? f_q - 8'd32 : 8'd32 - f_q;
		end
		if (state_q == T_CONV2) begin
			mag_q <= 7'(magp >> 16);
			// x*65535/315 = 208x + x/21
			sc_q  <= 16'(x9) * 16'd208 + 16'(divp >> 16) + 16'd1;
		end
		if (state_q == T_CONV3) begin
			c_q <= (cel8 > 8'd127) ? 7'd127 : cel8[6:0];
		end
	end

	// output register
	logic        o_kind;
	logic [1:0]  o_status;
	logic [7:0]  o_f;
	logic [6:0]  o_c, o_h;
	logic [15:0] o_sc;

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_kind   <= mode_q[0];
			o_status <= mode_q[0] ? hs_q : rstat_q;
			o_f      <= mode_q[0] ? 8'd0 : f_q;
			o_c      <= mode_q[0] ? 7'd0 : c_q;
			o_sc     <= mode_q[0] ? 16'd0 : sc_q;
			o_h      <= mode_q[0] ? hv_q : 7'd0;
		end
	end

	assign out_ch.valid               = out_v_q;
	assign out_ch.sensor_kind         = o_kind;
	assign out_ch.status              = o_status;
	assign out_ch.temp_fahrenheit     = o_f;
	assign out_ch.temp_celsius_offset = o_c;
	assign out_ch.temp_scaled         = o_sc;
	assign out_ch.humidity            = o_h;
endmodule

### tb/thermistor_humidity_linearizer_unit_tb.sv
// Testbench for the thermistor/humidity linearizer, checked against a predictor.
`timescale 1ns / 1ps
module thermistor_humidity_linearizer_unit_tb;
	import tlin_pkg::*;

	localparam int NTEMP = TEMP_ENTRIES_DEF;
	localparam int NROWS = HUM_ROWS_DEF;
	localparam int NCOLS = HUM_COLS_DEF;
	localparam int NHUM  = NROWS * NCOLS;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 40;
	// with the ascending table 30+3i, room samples up to this value give
	// Celsius+15 of 20 or less (humidity row 0) ...
	localparam int ROOM_LOW_MAX = 279;
	// ... and from this value 60 or more (last humidity row)
	localparam int ROOM_HIGH_MIN = 710;

	typedef logic [15:0] word_arr_t [0:255];

	typedef struct packed {
		logic [1:0]  mode;
		logic [11:0] addr;
		logic [15:0] word;
		logic [9:0]  sample;
	} lin_item_t;

	typedef struct packed {
		logic        kind;
		logic [1:0]  status;
		logic [7:0]  fahr;
		logic [6:0]  cels;
		logic [15:0] scaled;
		logic [6:0]  hum;
	} lin_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tlin_in_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) in_ch();
	tlin_out_if out_ch();

	thermistor_humidity_linearizer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// predictor state
	logic [15:0] temp_mem [0:NTEMP-1];
	logic [15:0] hum_mem [0:NHUM-1];
	int unsigned room_c_held, confirm_cnt, hum_st_held, hum_val_held;
	int unsigned lim_room_open, lim_room_short, lim_hum_short, lim_hum_open, lim_confirm;

	lin_item_t   pending_items[$];
	lin_result_t expected_results[$];
	lin_item_t   cur_item;

	int errors;
	int cycles;
	int results_seen;
	int burst_left, gap_left;
	int rx_mode, rx_phase_left, long_hold_left;
	bit long_hold_done;

	// clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// nearest ascending-table entry, ties to the higher index
	function automatic int nearest_entry(input word_arr_t tbl, input int n, input int v);
		int lo, hi, mid;
		logic [15:0] da, db, vv;
		lo = 0;
		hi = n - 1;
		mid = 0;
		vv = v[15:0];
		if (v <= int'(tbl[0])) return 0;
		if (v >= int'(tbl[n-1])) return n - 1;
		while (lo <= hi) begin
			mid = (lo + hi) >> 1;
			if (int'(tbl[mid]) == v) return mid;
			if (int'(tbl[mid]) > v) hi = mid - 1;
			else lo = mid + 1;
		end
		if (v < int'(tbl[mid])) begin
			if (mid == 0) return 0;
			da = tbl[mid] - vv;
			db = vv - tbl[mid-1];
			return (da <= db) ? mid : mid - 1;
		end
		if (mid + 1 >= n) return n - 1;
		da = tbl[mid+1] - vv;
		db = vv - tbl[mid];
		return (da <= db) ? mid + 1 : mid;
	endfunction

	// apply one accepted item to the predictor; queue its result if any
	task automatic predict_item(input lin_item_t it);
		lin_result_t r;
		word_arr_t tbl;
		int ad, f, c, mag, d, row, h;
		bit is_short, is_open;
		r = '0;
		if (it.mode == MODE_TEMP_LOAD) begin
			if (it.addr < NTEMP) temp_mem[it.addr] = it.word;
			return;
		end
		if (it.mode == MODE_HUM_LOAD) begin
			if (it.addr < NHUM) hum_mem[it.addr] = it.word;
			return;
		end
		if (it.mode == MODE_ROOM) begin
			ad = it.sample >> 1;
			f = 0;
			c = 0;
			r.status = ST_NORMAL;
			if (ad < lim_room_open) r.status = ST_OPEN;
			else if (ad > lim_room_short) r.status = ST_SHORT;
			else begin
				for (int i = 0; i < NTEMP; i++) tbl[i] = temp_mem[i];
				f = F_BASE + nearest_entry(tbl, NTEMP, ad);
				d = (f > 32) ? f - 32 : 32 - f;
				mag = (d * 10 + 9) / 18;
				c = (f < 32) ? C_OFFSET - mag : mag + C_OFFSET;
				r.scaled = 16'(((f + 49) * 65535) / 315 + 1);
			end
			room_c_held = c;
			r.fahr = 8'(f);
			r.cels = 7'(c);
		end else begin
			is_short = it.sample > lim_hum_short;
			is_open = !is_short && it.sample < lim_hum_open &&
				room_c_held >= OPEN_MIN_CELSIUS;
			if (is_short || is_open) begin
				if (confirm_cnt + 1 >= lim_confirm) begin
					confirm_cnt = lim_confirm;
					hum_st_held = is_short ? ST_SHORT : ST_OPEN;
					hum_val_held = is_short ? HUM_SHORT_VALUE : 0;
				end else begin
					confirm_cnt = (confirm_cnt + 1) & 7;
				end
			end else if (confirm_cnt > 0) begin
				confirm_cnt--;
			end else begin
				row = (room_c_held <= HUM_BASE) ? 0 : room_c_held - HUM_BASE;
				if (row > NROWS - 1) row = NROWS - 1;
				for (int j = 0; j < NCOLS; j++) tbl[j] = hum_mem[row*NCOLS + j];
				h = nearest_entry(tbl, NCOLS, it.sample) + HUM_BASE;
				hum_st_held = ST_NORMAL;
				hum_val_held = h;
			end
			r.kind = 1'b1;
			r.status = 2'(hum_st_held);
			r.hum = 7'(hum_val_held);
		end
		expected_results.push_back(r);
	endtask

	// sender: bursts and gaps; prediction happens on each transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.mode <= MODE_TEMP_LOAD;
			in_ch.table_addr <= '0;
			in_ch.table_word <= '0;
			in_ch.sample <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) predict_item(cur_item);
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left > 0) begin
					in_ch.valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_items.size() > 0) begin
					cur_item = pending_items.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.mode <= cur_item.mode;
					in_ch.table_addr <= cur_item.addr;
					in_ch.table_word <= cur_item.word;
					in_ch.sample <= cur_item.sample;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern picked at random for each phase; one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			rx_mode <= 0;
			rx_phase_left <= 0;
			long_hold_left <= 0;
			long_hold_done <= 1'b0;
		end else begin
			if (!long_hold_done && results_seen >= 40) begin
				long_hold_left <= 400;
				long_hold_done <= 1'b1;
				out_ch.ready <= 1'b0;
			end else if (long_hold_left > 0) begin
				long_hold_left <= long_hold_left - 1;
				out_ch.ready <= 1'b0;
			end else begin
				if (rx_phase_left == 0) begin
					rx_mode <= $urandom_range(0, 2);
					rx_phase_left <= $urandom_range(20, 80);
				end else begin
					rx_phase_left <= rx_phase_left - 1;
				end
				case (rx_mode)
				0: begin
					out_ch.ready <= 1'b1;
				end
				1: begin
					out_ch.ready <= ($urandom_range(0, 1) == 1);
				end
				default: begin
					out_ch.ready <= ($urandom_range(0, 3) == 0);
				end
				endcase
			end
		end
	end

	// monitor: compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		lin_result_t exp_r, got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen <= results_seen + 1;
			got = {out_ch.sensor_kind, out_ch.status, out_ch.temp_fahrenheit,
				out_ch.temp_celsius_offset, out_ch.temp_scaled, out_ch.humidity};
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %p", got);
			end else begin
				exp_r = expected_results.pop_front();
				if (got.kind !== exp_r.kind || got.status !== exp_r.status ||
					got.fahr !== exp_r.fahr || got.cels !== exp_r.cels ||
					got.scaled !== exp_r.scaled || got.hum !== exp_r.hum) begin
					errors++;
					if (errors <= 10) $display("mismatch: expected %p got %p", exp_r, got);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic add_item(input logic [1:0] m, input int a, input int w, input int s);
		lin_item_t it;
		it.mode = m;
		it.addr = 12'(a);
		it.word = 16'(w);
		it.sample = 10'(s);
		pending_items.push_back(it);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		case (idx)
		CFG_ROOM_OPEN: lim_room_open = val & 'h1FF;
		CFG_ROOM_SHORT: lim_room_short = val & 'h1FF;
		CFG_HUM_SHORT: lim_hum_short = val & 'h3FF;
		CFG_HUM_OPEN: lim_hum_open = val & 'h3FF;
		CFG_CONFIRM: lim_confirm = val & 'h7;
		default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_limits(input int ro, input int rs, input int hs, input int ho, input int fc);
		write_reg(CFG_ROOM_OPEN, ro);
		write_reg(CFG_ROOM_SHORT, rs);
		write_reg(CFG_HUM_SHORT, hs);
		write_reg(CFG_HUM_OPEN, ho);
		write_reg(CFG_CONFIRM, fc);
	endtask

	// wait until everything sent has been checked, then let the unit settle
	task automatic wait_idle();
		while (pending_items.size() > 0 || in_ch.valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// free_table: temperature table may go unsorted; then no humidity samples,
	// since the humidity row could land on one that was never loaded
	task automatic add_random(input int count, input bit free_table);
		int pick, s, a;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 7) begin
				if (free_table) begin
					add_item(MODE_TEMP_LOAD, $urandom_range(0, 4095), $urandom, $urandom);
				end else begin
					// rewrite an entry with its own value, or miss the table
					a = $urandom_range(0, 4095);
					add_item(MODE_TEMP_LOAD, a, 30 + 3 * a, $urandom);
				end
			end else if (pick < 14) begin
				add_item(MODE_HUM_LOAD, $urandom_range(0, 4095), $urandom, $urandom);
			end else if (pick < 50 || free_table) begin
				// keep the held Celsius on the loaded humidity rows
				if (free_table) s = $urandom_range(0, 1023);
				else if ($urandom_range(0, 1) == 0) s = $urandom_range(0, ROOM_LOW_MAX);
				else s = $urandom_range(ROOM_HIGH_MIN, 1023);
				add_item(MODE_ROOM, $urandom, $urandom, s);
			end else begin
				// bias toward fault runs so the confirm counter moves both ways
				case ($urandom_range(0, 3))
				0: s = $urandom_range(990, 1023);
				1: s = $urandom_range(0, 12);
				default: s = $urandom_range(0, 1023);
				endcase
				add_item(MODE_HUM, $urandom, $urandom, s);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		cycles = 0;
		results_seen = 0;
		room_c_held = 0;
		confirm_cnt = 0;
		hum_st_held = ST_NORMAL;
		hum_val_held = 0;
		lim_room_open = ROOM_OPEN_RST;
		lim_room_short = ROOM_SHORT_RST;
		lim_hum_short = HUM_SHORT_RST;
		lim_hum_open = HUM_OPEN_RST;
		lim_confirm = CONFIRM_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		set_limits(ROOM_OPEN_RST, ROOM_SHORT_RST, HUM_SHORT_RST, HUM_OPEN_RST, CONFIRM_RST);

		// fill the temperature table and the first and last humidity rows;
		// room samples below keep the held Celsius on those two rows
		for (int i = 0; i < NTEMP; i++) add_item(MODE_TEMP_LOAD, i, 30 + 3 * i, $urandom);
		for (int j = 0; j < NCOLS; j++) add_item(MODE_HUM_LOAD, j, j * 14, $urandom);
		for (int j = 0; j < NCOLS; j++)
			add_item(MODE_HUM_LOAD, (NROWS - 1) * NCOLS + j, j * 14 + (NROWS - 1) % 5, $urandom);

		// directed: out-of-range loads, limit edges, mid-table room, fault runs
		add_item(MODE_TEMP_LOAD, NTEMP, 16'hFFFF, 0);
		add_item(MODE_HUM_LOAD, NHUM, 16'h0000, 1023);
		add_item(MODE_HUM_LOAD, 4095, 16'hFFFF, 1023);
		add_item(MODE_ROOM, 0, 0, 0);
		add_item(MODE_ROOM, 4095, 16'hFFFF, 1023);
		add_item(MODE_ROOM, 0, 0, 58);
		add_item(MODE_ROOM, 0, 0, 60);
		add_item(MODE_ROOM, 0, 0, 1000);
		add_item(MODE_ROOM, 0, 0, 1002);
		add_item(MODE_ROOM, 0, 0, 2 * (30 + 3 * 70) + 2);
		// back onto the last humidity row before any lookup
		add_item(MODE_ROOM, 0, 0, 1000);
		add_item(MODE_HUM, 0, 0, 28);
		add_item(MODE_HUM, 0, 0, 35);
		for (int k = 0; k < 3; k++) add_item(MODE_HUM, 0, 0, 1023);
		for (int k = 0; k < 3; k++) add_item(MODE_HUM, 0, 0, 500);
		for (int k = 0; k < 3; k++) add_item(MODE_HUM, 0, 0, 0);
		add_item(MODE_ROOM, 0, 0, 80);
		for (int k = 0; k < 4; k++) add_item(MODE_HUM, 0, 0, 0);
		add_random(60, 1'b0);
		wait_idle();

		// widest limits, quickest confirm
		set_limits(0, 511, 1023, 0, 1);
		add_random(50, 1'b0);
		wait_idle();

		// narrowest limits, slowest confirm
		set_limits(511, 0, 0, 1023, 7);
		add_random(40, 1'b0);
		wait_idle();

		// mid-range limits with the temperature table scrambled
		set_limits($urandom_range(10, 60), $urandom_range(400, 511),
			$urandom_range(900, 1010), $urandom_range(5, 40), $urandom_range(2, 5));
		for (int i = 0; i < 40; i++)
			add_item(MODE_TEMP_LOAD, $urandom_range(0, NTEMP - 1), $urandom_range(0, 520), 0);
		add_random(40, 1'b1);
		wait_idle();

		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
